/* rtl/lxc_pkg.sv */
// shared types, character codes and the hex digit decoder for the line checksum checker
// no dependencies
`timescale 1ns / 1ps

package lxc_pkg;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam int         HEX_BITS  = 4;   // one digit of radix 16
   localparam int         RSP_BITS  = 24;  // result fields padded to whole bytes

   typedef struct packed {
      logic       star_seen;
      logic [7:0] received_sum;
      logic [7:0] computed_sum;
      logic       line_ok;
   } result_type;

   typedef struct packed {
      logic                is_hex;
      logic [HEX_BITS-1:0] value;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type d;
      d.is_hex = 1'b0;
      d.value  = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d.is_hex = 1'b1;
         d.value  = HEX_BITS'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d.is_hex = 1'b1;
         d.value  = HEX_BITS'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d.is_hex = 1'b1;
         d.value  = HEX_BITS'(b - 8'h37);
      end
      return d;
   endfunction

endpackage

/* rtl/lxc_parser.sv */
// line state tracker: start mark skip, xor sum up to the star, hex field decode
// depends on lxc_pkg
`timescale 1ns / 1ps

module lxc_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output logic                emit,
   output lxc_pkg::result_type result
);

   typedef enum logic [1:0] {
      PHASE_EMPTY,
      PHASE_SUM,
      PHASE_HEX,
      PHASE_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  hex_ff, hex_in;
   logic        line_end;
   logic        star;
   lxc_pkg::hex_type digit;

   assign line_end = (rx_byte == lxc_pkg::CH_LF) || (rx_byte == lxc_pkg::CH_CR);
   assign digit    = lxc_pkg::hex_digit(rx_byte);
   assign star     = (phase_ff != PHASE_SUM);

   // result of the line closed by this item
   assign emit                = line_end && (phase_ff != PHASE_EMPTY);
   assign result.star_seen    = star;
   assign result.received_sum = star ? hex_ff : 8'h00;
   assign result.computed_sum = xor_ff;
   assign result.line_ok      = star && (xor_ff == hex_ff);

   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      hex_in   = hex_ff;
      if (line_end) begin
         phase_in = PHASE_EMPTY;
         xor_in   = 8'h00;
         hex_in   = 8'h00;
      end else begin
         case (phase_ff)
            PHASE_EMPTY: begin
               phase_in = PHASE_SUM;
            end
            PHASE_SUM: begin
               if (rx_byte == lxc_pkg::CH_STAR) begin
                  phase_in = PHASE_HEX;
               end else begin
                  xor_in = xor_ff ^ rx_byte;
               end
            end
            PHASE_HEX: begin
               if (!digit.is_hex) begin
                  phase_in = PHASE_DONE;
               end else begin
                  // times 16 plus digit, low 8 bits kept
                  hex_in = {hex_ff[7-lxc_pkg::HEX_BITS:0], digit.value};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_EMPTY;
         xor_ff   <= 8'h00;
         hex_ff   <= 8'h00;
      end else if (step) begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         hex_ff   <= hex_in;
      end
   end

endmodule

/* rtl/lxc_out_reg.sv */
// result register toward the rsp channel, loads while empty or being drained
// depends on lxc_pkg
`timescale 1ns / 1ps

module lxc_out_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_valid,
   input  lxc_pkg::result_type         load_data,
   output logic                        free,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lxc_pkg::RSP_BITS-1:0] rsp_tdata
);

   logic                vld_ff, vld_in;
   lxc_pkg::result_type data_ff, data_in;

   assign free    = !vld_ff || rsp_tready;
   assign vld_in  = free ? load_valid : vld_ff;
   assign data_in = (free && load_valid) ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {{(lxc_pkg::RSP_BITS - $bits(lxc_pkg::result_type)){1'b0}}, data_ff};

endmodule

/* rtl/line_xor_checksum_checker.sv */
// line xor checksum checker top level: input register, line parser, result register
// depends on lxc_pkg, lxc_parser, lxc_out_reg
// a cr or lf item passes the input register, and its result then the result register, before it leaves on rsp
// throughput: one item per cycle while no result is held on rsp, set by the line state update
// lines that hold no byte before cr or lf give no result
// reset clears the line state and both valid flags, synchronous and active high
`timescale 1ns / 1ps

module line_xor_checksum_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] line_ok, [8:1] computed_sum,
                                    // [16:9] received_sum, [17] star_seen
);

   logic                in_vld_ff, in_vld_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                out_free;
   logic                step;
   logic                emit;
   lxc_pkg::result_type result;

   // the input register drains whenever the result register can take its outcome
   assign step       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;
   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign in_byte_in = (req_tready && req_tvalid) ? req_tdata : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   lxc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   lxc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (step && emit),
      .load_data  (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // input side stalls only when a result is held on rsp
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

   // a good line has a star and matching sums
   a_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[17] && rsp_tdata[8:1] == rsp_tdata[16:9]))
      else $error("line_ok without star or matching sums");

   // no star means no received sum
   a_no_star_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[17]) |-> (rsp_tdata[16:9] == 8'h00 && !rsp_tdata[0]))
      else $error("received_sum or line_ok set without a star");

   // a result appears only after an input item was taken by the parser
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(in_vld_ff))
      else $error("result appeared with no item in the input register");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:18] == 6'd0))
      else $error("rsp padding bits not zero");

endmodule
